FILE: hw/rtl/gsr_pkg.sv
// ---------------------------------------------------------------------------
// gsr_pkg
// Types and constants of the generational slot registry.
// ---------------------------------------------------------------------------
package gsr_pkg;

  localparam int SLOTS       = 32;
  localparam int SLOT_W      = 5;
  localparam int TAG_ENTRIES = 32;
  localparam int TAG_BITS    = 16;
  localparam int GEN_BITS    = 16;
  localparam int SRC_W       = 64;
  localparam int CNT_W       = 6;

  typedef enum logic [1:0] {
    FN_REGISTER    = 2'd0,
    FN_RELEASE     = 2'd1,
    FN_RELEASE_SRC = 2'd2,
    FN_RESET       = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG_SCAN,
    ST_REL_SCAN,
    ST_SRC_SCAN,
    ST_RST_SCAN
  } state_t;

  typedef struct packed {
    logic [1:0]          func;
    logic [SLOT_W-1:0]   slot_index;
    logic [GEN_BITS-1:0] handle_generation;
    logic [SRC_W-1:0]    source_id;
    logic [TAG_BITS-1:0] event_tag;
    logic                chain_valid;
    logic                bus_present;
  } in_t;

  typedef struct packed {
    logic                ok;
    logic [SLOT_W-1:0]   out_slot;
    logic [GEN_BITS-1:0] out_generation;
    logic [TAG_BITS-1:0] out_tag;
    logic                subscribe;
    logic                unsubscribe;
    logic [CNT_W-1:0]    removed_count;
    logic                full_res;
    logic                last;
  } out_t;

endpackage

FILE: hw/rtl/generational_slot_registry_top.sv
// ---------------------------------------------------------------------------
// generational_slot_registry_top
// Slot registry with free-slot stack, per-slot generations and tag table.
// ---------------------------------------------------------------------------
// Usage:
//   Input: drive in_data and pulse start while busy is low; the transaction
//   is taken at that edge; a scan holds busy high until the last result.
//   Results: out_valid is high for exactly one cycle per result, with
//   out_data; out_data.last marks the final result of the transaction.
//   Config: cfg_we with cfg_wdata writes evaluator_ready; write while idle.
// Timing (one shared compare unit, one table entry per cycle):
//   rejected or full register, stale release: result in the cycle after start.
//   register, release: one pass over the tag table / slots.
//   release by source: a slot pass plus a release pass per removed row.
//   reset: bus present: a tag table pass; else the cycle after start.
// Reset: rst_n low clears all generations, the tag table, the stack and
//   counters and evaluator_ready. The receiver cannot stall; results are
//   never held back.
// ---------------------------------------------------------------------------
module generational_slot_registry_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  gsr_pkg::in_t  in_data,
  output logic          out_valid,
  output gsr_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  localparam int SW = gsr_pkg::SLOT_W;
  localparam int CW = gsr_pkg::CNT_W;
  localparam int GB = gsr_pkg::GEN_BITS;
  localparam int TB = gsr_pkg::TAG_BITS;
  localparam logic [SW-1:0] LAST_IDX = SW'(gsr_pkg::SLOTS - 1);
  localparam logic [CW-1:0] SLOTS_C  = CW'(gsr_pkg::SLOTS);
  localparam logic [CW-1:0] TE_C     = CW'(gsr_pkg::TAG_ENTRIES);

  gsr_pkg::state_t state_r, state_nxt;
  gsr_pkg::in_t    item_r, item_nxt;
  gsr_pkg::out_t   out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            ready_r;

  logic [GB-1:0]             gen_r [gsr_pkg::SLOTS];
  logic [TB-1:0]             stag_r [gsr_pkg::SLOTS];
  logic [gsr_pkg::SRC_W-1:0] ssrc_r [gsr_pkg::SLOTS];
  logic [SW-1:0]             stk_r [gsr_pkg::SLOTS];
  logic [TB-1:0]             ttag_r [gsr_pkg::TAG_ENTRIES];
  logic [gsr_pkg::TAG_ENTRIES-1:0] tv_r;

  logic [CW-1:0] fc_r, fc_nxt, used_r, used_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt, cur_r, cur_nxt, fidx_r, fidx_nxt, freei_r, freei_nxt;
  logic [CW-1:0] outer_r, outer_nxt, removed_r, removed_nxt;
  logic [GB-1:0] gnew_r, gnew_nxt;
  logic [TB-1:0] rtag_r, rtag_nxt;
  logic          found_r, found_nxt, ffree_r, ffree_nxt, live_r, live_nxt;

  logic [SW-1:0] gen_ra, stag_ra, ttag_ra, stk_ra;
  logic [GB-1:0] gen_rd;
  logic [TB-1:0] stag_rd, ttag_rd;
  logic [SW-1:0] stk_rd;

  logic          gen_we, stk_we, slot_we, tv_set, tv_clr, clr_all;
  logic [SW-1:0] gen_wa, stk_wa, tv_idx;
  logic [GB-1:0] gen_wd;
  logic [SW-1:0] stk_wd;

  logic          rel_go;
  logic [SW-1:0] rel_slot;
  logic          hit, found_c, live_c, ffree_c, sub_c, unsub_c;
  logic [SW-1:0] fidx_c, freei_c, pop_slot;
  gsr_pkg::func_t fn;

  assign busy      = (state_r != gsr_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign fn        = gsr_pkg::func_t'(busy ? item_r.func : in_data.func);

  assign stk_ra  = SW'(fc_r - CW'(1));
  assign stk_rd  = stk_r[stk_ra];
  assign gen_rd  = gen_r[gen_ra];
  assign stag_rd = stag_r[stag_ra];
  assign ttag_rd = ttag_r[ttag_ra];
  assign pop_slot = stk_rd;

  always_comb begin
    case (state_r)
      gsr_pkg::ST_IDLE: begin
        gen_ra  = (fn == gsr_pkg::FN_REGISTER) ? pop_slot : in_data.slot_index;
        stag_ra = in_data.slot_index;
      end
      gsr_pkg::ST_REL_SCAN: begin
        gen_ra  = cnt_r;
        stag_ra = cnt_r;
      end
      default: begin
        gen_ra  = outer_r[SW-1:0];
        stag_ra = outer_r[SW-1:0];
      end
    endcase
    ttag_ra = (state_r == gsr_pkg::ST_RST_SCAN) ? outer_r[SW-1:0] : cnt_r;
  end

  always_comb begin
    hit     = tv_r[cnt_r] && (ttag_rd == rtag_r);
    found_c = found_r || hit;
    fidx_c  = (hit && !found_r) ? cnt_r : fidx_r;
    ffree_c = ffree_r || !tv_r[cnt_r];
    freei_c = (!tv_r[cnt_r] && !ffree_r) ? cnt_r : freei_r;
    live_c  = live_r || (gen_rd[0] && (stag_rd == rtag_r));
    sub_c   = !found_c && ready_r && ffree_c;
    unsub_c = !live_c && found_c;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    out_nxt       = '0;
    out_valid_nxt = 1'b0;
    fc_nxt        = fc_r;
    used_nxt      = used_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    fidx_nxt      = fidx_r;
    freei_nxt     = freei_r;
    outer_nxt     = outer_r;
    removed_nxt   = removed_r;
    gnew_nxt      = gnew_r;
    rtag_nxt      = rtag_r;
    found_nxt     = found_r;
    ffree_nxt     = ffree_r;
    live_nxt      = live_r;
    gen_we        = 1'b0;
    gen_wa        = '0;
    gen_wd        = '0;
    stk_we        = 1'b0;
    stk_wa        = fc_r[SW-1:0];
    stk_wd        = '0;
    slot_we       = 1'b0;
    tv_set        = 1'b0;
    tv_clr        = 1'b0;
    tv_idx        = '0;
    clr_all       = 1'b0;
    rel_go        = 1'b0;
    rel_slot      = '0;

    case (state_r)
      gsr_pkg::ST_IDLE: begin
        if (start) begin
          item_nxt = in_data;
          case (fn)
            gsr_pkg::FN_REGISTER: begin
              if (in_data.event_tag == '0 || !in_data.chain_valid || !in_data.bus_present) begin
                out_valid_nxt = 1'b1;
                out_nxt.last  = 1'b1;
              end else if (fc_r != '0) begin
                fc_nxt    = fc_r - CW'(1);
                cur_nxt   = pop_slot;
                gnew_nxt  = gen_rd + GB'(1);
                gen_we    = 1'b1;
                gen_wa    = pop_slot;
                gen_wd    = gen_rd + GB'(1);
                slot_we   = 1'b1;
                state_nxt = gsr_pkg::ST_REG_SCAN;
              end else if (used_r != SLOTS_C) begin
                used_nxt  = used_r + CW'(1);
                cur_nxt   = used_r[SW-1:0];
                gnew_nxt  = GB'(1);
                gen_we    = 1'b1;
                gen_wa    = used_r[SW-1:0];
                gen_wd    = GB'(1);
                slot_we   = 1'b1;
                state_nxt = gsr_pkg::ST_REG_SCAN;
              end else begin
                out_valid_nxt    = 1'b1;
                out_nxt.full_res = 1'b1;
                out_nxt.last     = 1'b1;
              end
              rtag_nxt  = in_data.event_tag;
              cnt_nxt   = '0;
              found_nxt = 1'b0;
              ffree_nxt = 1'b0;
            end
            gsr_pkg::FN_RELEASE: begin
              if (!gen_rd[0] || gen_rd != in_data.handle_generation) begin
                out_valid_nxt = 1'b1;
                out_nxt.last  = 1'b1;
              end else begin
                rel_go   = 1'b1;
                rel_slot = in_data.slot_index;
              end
            end
            gsr_pkg::FN_RELEASE_SRC: begin
              if (in_data.source_id == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt.last  = 1'b1;
              end else begin
                outer_nxt   = '0;
                removed_nxt = '0;
                state_nxt   = gsr_pkg::ST_SRC_SCAN;
              end
            end
            default: begin
              if (in_data.bus_present) begin
                outer_nxt = '0;
                state_nxt = gsr_pkg::ST_RST_SCAN;
              end else begin
                clr_all       = 1'b1;
                fc_nxt        = '0;
                used_nxt      = '0;
                out_valid_nxt = 1'b1;
                out_nxt.ok    = 1'b1;
                out_nxt.last  = 1'b1;
              end
            end
          endcase
        end
      end
      gsr_pkg::ST_REG_SCAN: begin
        found_nxt = found_c;
        ffree_nxt = ffree_c;
        freei_nxt = freei_c;
        cnt_nxt   = cnt_r + SW'(1);
        if (cnt_r == LAST_IDX) begin
          tv_set                 = sub_c;
          tv_idx                 = freei_c;
          out_valid_nxt          = 1'b1;
          out_nxt.ok             = 1'b1;
          out_nxt.out_slot       = cur_r;
          out_nxt.out_generation = gnew_r;
          out_nxt.out_tag        = rtag_r;
          out_nxt.subscribe      = sub_c;
          out_nxt.last           = 1'b1;
          state_nxt              = gsr_pkg::ST_IDLE;
        end
      end
      gsr_pkg::ST_REL_SCAN: begin
        found_nxt = found_c;
        fidx_nxt  = fidx_c;
        live_nxt  = live_c;
        cnt_nxt   = cnt_r + SW'(1);
        if (cnt_r == LAST_IDX) begin
          tv_clr                 = unsub_c;
          tv_idx                 = fidx_c;
          out_valid_nxt          = 1'b1;
          out_nxt.ok             = 1'b1;
          out_nxt.out_slot       = cur_r;
          out_nxt.out_generation = gnew_r;
          out_nxt.out_tag        = rtag_r;
          out_nxt.unsubscribe    = unsub_c && item_r.bus_present;
          if (item_r.func == gsr_pkg::FN_RELEASE) begin
            out_nxt.last = 1'b1;
            state_nxt    = gsr_pkg::ST_IDLE;
          end else begin
            removed_nxt = removed_r + CW'(1);
            outer_nxt   = outer_r + CW'(1);
            state_nxt   = gsr_pkg::ST_SRC_SCAN;
          end
        end
      end
      gsr_pkg::ST_SRC_SCAN: begin
        if (outer_r == SLOTS_C) begin
          out_valid_nxt         = 1'b1;
          out_nxt.ok            = 1'b1;
          out_nxt.removed_count = removed_r;
          out_nxt.last          = 1'b1;
          state_nxt             = gsr_pkg::ST_IDLE;
        end else if (gen_rd[0] && ssrc_r[outer_r[SW-1:0]] == item_r.source_id) begin
          rel_go   = 1'b1;
          rel_slot = outer_r[SW-1:0];
        end else begin
          outer_nxt = outer_r + CW'(1);
        end
      end
      gsr_pkg::ST_RST_SCAN: begin
        if (outer_r == TE_C) begin
          clr_all       = 1'b1;
          fc_nxt        = '0;
          used_nxt      = '0;
          out_valid_nxt = 1'b1;
          out_nxt.ok    = 1'b1;
          out_nxt.last  = 1'b1;
          state_nxt     = gsr_pkg::ST_IDLE;
        end else begin
          out_valid_nxt       = tv_r[outer_r[SW-1:0]];
          out_nxt.ok          = 1'b1;
          out_nxt.out_tag     = ttag_rd;
          out_nxt.unsubscribe = 1'b1;
          outer_nxt           = outer_r + CW'(1);
        end
      end
      default: state_nxt = gsr_pkg::ST_IDLE;
    endcase

    if (rel_go) begin
      gen_we    = 1'b1;
      gen_wa    = rel_slot;
      gen_wd    = gen_rd + GB'(1);
      gnew_nxt  = gen_rd + GB'(1);
      stk_we    = 1'b1;
      stk_wd    = rel_slot;
      fc_nxt    = fc_r + CW'(1);
      cur_nxt   = rel_slot;
      rtag_nxt  = stag_r[rel_slot];
      cnt_nxt   = '0;
      live_nxt  = 1'b0;
      found_nxt = 1'b0;
      state_nxt = gsr_pkg::ST_REL_SCAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gsr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      ready_r     <= 1'b0;
      fc_r        <= '0;
      used_r      <= '0;
      tv_r        <= '0;
      for (int i = 0; i < gsr_pkg::SLOTS; i++) begin
        gen_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fc_r        <= fc_nxt;
      used_r      <= used_nxt;
      if (cfg_we) begin
        ready_r <= cfg_wdata;
      end
      if (clr_all) begin
        tv_r <= '0;
        for (int i = 0; i < gsr_pkg::SLOTS; i++) begin
          gen_r[i] <= '0;
        end
      end else begin
        if (gen_we) begin
          gen_r[gen_wa] <= gen_wd;
        end
        if (tv_set) begin
          tv_r[tv_idx] <= 1'b1;
        end
        if (tv_clr) begin
          tv_r[tv_idx] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    out_r     <= out_nxt;
    cnt_r     <= cnt_nxt;
    cur_r     <= cur_nxt;
    fidx_r    <= fidx_nxt;
    freei_r   <= freei_nxt;
    outer_r   <= outer_nxt;
    removed_r <= removed_nxt;
    gnew_r    <= gnew_nxt;
    rtag_r    <= rtag_nxt;
    found_r   <= found_nxt;
    ffree_r   <= ffree_nxt;
    live_r    <= live_nxt;
    if (slot_we) begin
      stag_r[cur_nxt] <= in_data.event_tag;
      ssrc_r[cur_nxt] <= in_data.source_id;
    end
    if (stk_we) begin
      stk_r[stk_wa] <= stk_wd;
    end
    if (tv_set) begin
      ttag_r[tv_idx] <= rtag_r;
    end
  end

`ifndef SYNTHESIS
  a_fc_le_used: assert property (@(posedge clk) disable iff (!rst_n) fc_r <= used_r)
    else $error("free count exceeds used slots");
  a_used_range: assert property (@(posedge clk) disable iff (!rst_n) used_r <= SLOTS_C)
    else $error("used slots out of range");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.last |-> !busy)
    else $error("busy after final result");
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.last |-> busy)
    else $error("idle before final result");
  a_sub_unsub: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.subscribe && out_r.unsubscribe))
    else $error("subscribe and unsubscribe together");
`endif

endmodule
